FILE: rtl/scle_pkg.sv
// shared types, scan code constants and lookup tables for the scan code line editor
package scle_pkg;

    localparam int unsigned CAP_W     = 7;
    localparam int unsigned FILL_W    = 8;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned TAB_CNT_W = 3;

    localparam logic [CAP_W-1:0]     CAP_RESET   = 7'd127;
    localparam logic [TAB_CNT_W-1:0] TAB_LAST    = 3'd7;

    typedef enum logic [2:0] {
        EV_ECHO     = 3'd0,
        EV_ERASE    = 3'd1,
        EV_LEFT     = 3'd2,
        EV_RIGHT    = 3'd3,
        EV_LINE_END = 3'd4,
        EV_REDRAW   = 3'd5
    } ev_kind_t;

    // scan codes with dedicated handling
    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS        = 8'h3A;
    localparam logic [CODE_W-1:0] SC_CTRL_MAKE   = 8'h1D;
    localparam logic [CODE_W-1:0] SC_CTRL_BRK    = 8'h9D;
    localparam logic [CODE_W-1:0] SC_ALT_MAKE    = 8'h38;
    localparam logic [CODE_W-1:0] SC_ALT_BRK     = 8'hB8;
    localparam logic [CODE_W-1:0] SC_UP          = 8'h48;
    localparam logic [CODE_W-1:0] SC_DOWN        = 8'h50;
    localparam logic [CODE_W-1:0] SC_LEFT        = 8'h4B;
    localparam logic [CODE_W-1:0] SC_RIGHT       = 8'h4D;
    localparam logic [CODE_W-1:0] SC_FIRST_BRK   = 8'h3B;

    // ascii values with special meaning
    localparam logic [CHAR_W-1:0] CH_NONE   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BS     = 7'h08;
    localparam logic [CHAR_W-1:0] CH_TAB    = 7'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_LOW_L  = 7'h6C;
    localparam logic [CHAR_W-1:0] CASE_DIFF = 7'h20;

    // make codes 0x00..0x3A, padded to 64 entries
    localparam logic [CHAR_W-1:0] KEY_TABLE [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // shifted form of digits and punctuation
    function automatic logic [CHAR_W-1:0] shift_map(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] res;
        begin
            case (ch)
                7'h60:   res = 7'h7E;
                7'h31:   res = 7'h21;
                7'h32:   res = 7'h40;
                7'h33:   res = 7'h23;
                7'h34:   res = 7'h24;
                7'h35:   res = 7'h25;
                7'h36:   res = 7'h5E;
                7'h37:   res = 7'h26;
                7'h38:   res = 7'h2A;
                7'h39:   res = 7'h28;
                7'h30:   res = 7'h29;
                7'h2D:   res = 7'h5F;
                7'h3D:   res = 7'h2B;
                7'h5B:   res = 7'h7B;
                7'h5D:   res = 7'h7D;
                7'h5C:   res = 7'h7C;
                7'h3B:   res = 7'h3A;
                7'h27:   res = 7'h22;
                7'h2C:   res = 7'h3C;
                7'h2E:   res = 7'h3E;
                7'h2F:   res = 7'h3F;
                default: res = ch;
            endcase
            return res;
        end
    endfunction

endpackage

FILE: rtl/scan_code_line_editor_top.sv
// set-1 scan code line editor: modifier tracking, ascii mapping and line editing events
//
// input channel: key_code with in_valid / in_ready, one transfer per raw scan code byte.
// output channel: event_kind, character, last_of_run and fill_level with out_valid /
// out_ready; a code gives zero or more events, last_of_run marks its final one.
// configuration: line_capacity is written through cfg_we / cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// path: a code waits in the input register, its events come from the result register.
// throughput, while out_ready is high: one code per cycle for codes with at most one
// event; a tab gives up to eight space events, one per cycle from the result register,
// and the input register holds further codes until the last space has gone out.
// reset: modifiers, fill count and cursor clear, capacity returns to 127, both
// channels come up empty.
// stall: when out_ready is low the result register holds, the input register keeps
// its code and in_ready falls once it is occupied; nothing is dropped.
module scan_code_line_editor_top
    import scle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CODE_W-1:0] key_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        event_kind,
    output logic [CHAR_W-1:0] character,
    output logic              last_of_run,
    output logic [FILL_W-1:0] fill_level
);

    logic [CAP_W-1:0]     cap_reg;
    logic                 code_valid_reg, code_valid_next;
    logic [CODE_W-1:0]    code_reg;
    logic                 lshift_reg, lshift_next;
    logic                 rshift_reg, rshift_next;
    logic                 caps_reg, caps_next;
    logic                 ctrl_reg, ctrl_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    cursor_reg, cursor_next;
    logic                 tab_active_reg, tab_active_next;
    logic [TAB_CNT_W-1:0] tab_cnt_reg, tab_cnt_next;
    logic                 out_valid_reg;
    ev_kind_t             kind_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    logic [FILL_W-1:0]    level_reg;

    logic                 out_free;
    logic                 proc_fire;
    logic                 in_fire;
    logic                 emit;
    ev_kind_t             ev_kind;
    logic [CHAR_W-1:0]    ev_char;
    logic                 ev_last;
    logic [CHAR_W-1:0]    key_ch;
    logic [CHAR_W-1:0]    up_ch;
    logic                 shift;
    logic [FILL_W-1:0]    cap_ext;
    logic [FILL_W-1:0]    fill_inc;
    logic                 line_full;

    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = code_valid_reg && !tab_active_reg && out_free;
    assign in_ready  = !code_valid_reg || proc_fire;
    assign in_fire   = in_valid && in_ready;

    assign cap_ext   = {1'b0, cap_reg};
    assign fill_inc  = fill_reg + 8'd1;
    assign line_full = fill_reg >= cap_ext;
    assign key_ch    = KEY_TABLE[code_reg[5:0]];
    assign shift     = lshift_reg || rshift_reg;
    assign up_ch     = ((caps_reg != shift) && (key_ch inside {[CH_LOW_A:CH_LOW_Z]}))
                       ? key_ch - CASE_DIFF : key_ch;

    assign code_valid_next = in_fire || (code_valid_reg && !proc_fire);

    always_comb
    begin
        lshift_next     = lshift_reg;
        rshift_next     = rshift_reg;
        caps_next       = caps_reg;
        ctrl_next       = ctrl_reg;
        fill_next       = fill_reg;
        cursor_next     = cursor_reg;
        tab_active_next = tab_active_reg;
        tab_cnt_next    = tab_cnt_reg;
        emit            = 1'b0;
        ev_kind         = EV_ECHO;
        ev_char         = CH_NONE;
        ev_last         = 1'b1;

        if (tab_active_reg)
        begin
            // remaining spaces of a tab run
            if (out_free)
            begin
                emit            = 1'b1;
                ev_char         = CH_SPACE;
                fill_next       = fill_inc;
                ev_last         = (tab_cnt_reg == TAB_LAST) || (fill_inc >= cap_ext);
                tab_cnt_next    = tab_cnt_reg + 3'd1;
                tab_active_next = !ev_last;
            end
        end
        else if (proc_fire)
        begin
            case (code_reg)
                SC_LSHIFT_MAKE: lshift_next = 1'b1;
                SC_LSHIFT_BRK:  lshift_next = 1'b0;
                SC_RSHIFT_MAKE: rshift_next = 1'b1;
                SC_RSHIFT_BRK:  rshift_next = 1'b0;
                SC_CAPS:        caps_next   = !caps_reg;
                SC_CTRL_MAKE:   ctrl_next   = 1'b1;
                SC_CTRL_BRK:    ctrl_next   = 1'b0;
                SC_ALT_MAKE, SC_ALT_BRK, SC_UP, SC_DOWN: ;
                SC_LEFT:
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - 8'd1;
                        emit        = 1'b1;
                        ev_kind     = EV_LEFT;
                    end
                end
                SC_RIGHT:
                begin
                    if (cursor_reg < fill_reg)
                    begin
                        cursor_next = cursor_reg + 8'd1;
                        emit        = 1'b1;
                        ev_kind     = EV_RIGHT;
                    end
                end
                default:
                begin
                    if (code_reg < SC_FIRST_BRK)
                    begin
                        if (key_ch == CH_BS)
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_reg - 8'd1;
                                if (cursor_reg != '0)
                                    cursor_next = cursor_reg - 8'd1;
                                emit    = 1'b1;
                                ev_kind = EV_ERASE;
                            end
                        end
                        else if (key_ch == CH_LF)
                        begin
                            fill_next   = '0;
                            cursor_next = '0;
                            emit        = 1'b1;
                            ev_kind     = EV_LINE_END;
                            ev_char     = CH_LF;
                        end
                        else if (ctrl_reg && key_ch == CH_LOW_L)
                        begin
                            emit    = 1'b1;
                            ev_kind = EV_REDRAW;
                        end
                        else if (key_ch != CH_NONE && !line_full)
                        begin
                            emit      = 1'b1;
                            fill_next = fill_inc;
                            if (key_ch == CH_TAB)
                            begin
                                // first space now, the rest from the tab run
                                ev_char         = CH_SPACE;
                                ev_last         = fill_inc >= cap_ext;
                                tab_active_next = !ev_last;
                                tab_cnt_next    = 3'd1;
                            end
                            else
                            begin
                                ev_char = shift ? shift_map(up_ch) : up_ch;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            code_valid_reg <= 1'b0;
            lshift_reg     <= 1'b0;
            rshift_reg     <= 1'b0;
            caps_reg       <= 1'b0;
            ctrl_reg       <= 1'b0;
            fill_reg       <= '0;
            cursor_reg     <= '0;
            tab_active_reg <= 1'b0;
            tab_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            code_valid_reg <= code_valid_next;
            lshift_reg     <= lshift_next;
            rshift_reg     <= rshift_next;
            caps_reg       <= caps_next;
            ctrl_reg       <= ctrl_next;
            fill_reg       <= fill_next;
            cursor_reg     <= cursor_next;
            tab_active_reg <= tab_active_next;
            tab_cnt_reg    <= tab_cnt_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            code_reg <= key_code;
        if (emit)
        begin
            kind_reg  <= ev_kind;
            char_reg  <= ev_char;
            last_reg  <= ev_last;
            level_reg <= fill_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign character   = char_reg;
    assign last_of_run = last_reg;
    assign fill_level  = level_reg;

endmodule

FILE: rtl/scle_checker.sv
// port-level checks on the scan code line editor, bound to the top level
module scle_checker
    import scle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        event_kind,
    input logic [CHAR_W-1:0] character,
    input logic              last_of_run,
    input logic [FILL_W-1:0] fill_level
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(character)
            && $stable(last_of_run) && $stable(fill_level))
        else $error("result changed while stalled");

    // line end always closes its run with an empty line and a line feed
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_LINE_END |->
            fill_level == '0 && character == CH_LF && last_of_run)
        else $error("bad line end event");

    // only echo can be part of a longer run, and only echo and line end carry a character
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_ECHO && event_kind != EV_LINE_END |->
            character == CH_NONE && last_of_run)
        else $error("non-echo event with character or open run");

    // consecutive echoes within a run each add one to the fill count
    a_run_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run ##1 out_valid |->
            event_kind == EV_ECHO && character == CH_SPACE
            && fill_level == $past(fill_level) + 8'd1)
        else $error("tab run fill count not stepping");

endmodule

bind scan_code_line_editor_top scle_checker u_scle_checker (.*);

FILE: sim/tb.sv
// self-checking testbench for the scan code line editor top level
`timescale 1ns / 1ps

module tb;
    import scle_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_GAP       = 40;
    localparam int MAX_REPORTS   = 40;

    // scan codes without a name in the package
    localparam logic [7:0] KEY_NONE    = 8'h00;
    localparam logic [7:0] KEY_1       = 8'h02;
    localparam logic [7:0] KEY_BKSP    = 8'h0E;
    localparam logic [7:0] KEY_TAB     = 8'h0F;
    localparam logic [7:0] KEY_ENTER   = 8'h1C;
    localparam logic [7:0] KEY_A       = 8'h1E;
    localparam logic [7:0] KEY_L       = 8'h26;
    localparam logic [7:0] KEY_SLASH   = 8'h35;
    localparam logic [7:0] KEY_TOP     = 8'hFF;
    localparam logic [7:0] BREAK_FLAG  = 8'h80;

    localparam logic [6:0] CHR_NONE    = 7'h00;
    localparam logic [6:0] CHR_BS      = 7'h08;
    localparam logic [6:0] CHR_TAB     = 7'h09;
    localparam logic [6:0] CHR_LF      = 7'h0A;
    localparam logic [6:0] CHR_SPACE   = 7'h20;
    localparam logic [6:0] CHR_LOW_A   = 7'h61;
    localparam logic [6:0] CHR_LOW_Z   = 7'h7A;
    localparam logic [6:0] CHR_LOW_L   = 7'h6C;
    localparam logic [6:0] CASE_OFFSET = 7'h20;

    // ascii of set-1 make codes 0x00..0x3a
    localparam logic [6:0] SET1_ASCII [59] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // punctuation and digits with their shifted partners
    localparam logic [6:0] PLAIN_PUNCT [21] = '{
        7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
        7'h30, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h3B, 7'h27, 7'h2C, 7'h2E, 7'h2F
    };
    localparam logic [6:0] SHIFTED_PUNCT [21] = '{
        7'h7E, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28,
        7'h29, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h3A, 7'h22, 7'h3C, 7'h3E, 7'h3F
    };

    typedef struct packed {
        ev_kind_t    kind;
        logic [6:0]  ch;
        logic        last;
        logic [7:0]  fill;
    } line_event_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [CODE_W-1:0] key_code  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        event_kind;
    logic [CHAR_W-1:0] character;
    logic              last_of_run;
    logic [FILL_W-1:0] fill_level;

    // editor state as the block should hold it
    logic       lshift_down = 1'b0;
    logic       rshift_down = 1'b0;
    logic       caps_on     = 1'b0;
    logic       ctrl_down   = 1'b0;
    logic [7:0] line_len    = '0;
    logic [7:0] cursor_at   = '0;
    logic [6:0] cap_limit   = 7'd127;

    line_event_t pending_events[$];
    line_event_t run_buf [8];
    int          run_len;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit hold_rx       = 1'b0;
    int error_count   = 0;
    int counted_items = 0;

    scan_code_line_editor_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_code    (key_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .character   (character),
        .last_of_run (last_of_run),
        .fill_level  (fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void add_event(input ev_kind_t kind, input logic [6:0] ch);
        run_buf[run_len] = '{kind, ch, 1'b0, line_len};
        run_len++;
    endfunction

    function automatic void decode_make(input logic [6:0] key_ch);
        logic [6:0] c;
        logic       shifted;
        int         i;
        c = key_ch;
        if (c == CHR_BS)
        begin
            if (line_len != 0)
            begin
                line_len--;
                if (cursor_at != 0)
                    cursor_at--;
                add_event(EV_ERASE, CHR_NONE);
            end
        end
        else if (c == CHR_LF)
        begin
            line_len  = '0;
            cursor_at = '0;
            add_event(EV_LINE_END, CHR_LF);
        end
        // ctrl+l wins even on a full line
        else if (ctrl_down && c == CHR_LOW_L)
            add_event(EV_REDRAW, CHR_NONE);
        else if (c != CHR_NONE && line_len < {1'b0, cap_limit})
        begin
            if (c == CHR_TAB)
            begin
                for (i = 0; i < 8 && line_len < {1'b0, cap_limit}; i++)
                begin
                    line_len++;
                    add_event(EV_ECHO, CHR_SPACE);
                end
            end
            else
            begin
                shifted = lshift_down || rshift_down;
                if ((caps_on != shifted) && (c inside {[CHR_LOW_A:CHR_LOW_Z]}))
                    c = c - CASE_OFFSET;
                if (shifted)
                begin
                    for (i = 0; i < 21; i++)
                    begin
                        if (PLAIN_PUNCT[i] == c)
                        begin
                            c = SHIFTED_PUNCT[i];
                            break;
                        end
                    end
                end
                line_len++;
                add_event(EV_ECHO, c);
            end
        end
    endfunction

    function automatic void predict_code(input logic [7:0] code);
        line_event_t e;
        int          i;
        run_len = 0;
        case (code)
            SC_LSHIFT_MAKE: lshift_down = 1'b1;
            SC_LSHIFT_BRK:  lshift_down = 1'b0;
            SC_RSHIFT_MAKE: rshift_down = 1'b1;
            SC_RSHIFT_BRK:  rshift_down = 1'b0;
            SC_CAPS:        caps_on     = !caps_on;
            SC_CTRL_MAKE:   ctrl_down   = 1'b1;
            SC_CTRL_BRK:    ctrl_down   = 1'b0;
            SC_ALT_MAKE, SC_ALT_BRK, SC_UP, SC_DOWN: ;
            SC_LEFT:
            begin
                if (cursor_at != 0)
                begin
                    cursor_at--;
                    add_event(EV_LEFT, CHR_NONE);
                end
            end
            SC_RIGHT:
            begin
                if (cursor_at < line_len)
                begin
                    cursor_at++;
                    add_event(EV_RIGHT, CHR_NONE);
                end
            end
            default:
            begin
                if (code < SC_FIRST_BRK)
                    decode_make(SET1_ASCII[code[5:0]]);
            end
        endcase
        for (i = 0; i < run_len; i++)
        begin
            e      = run_buf[i];
            e.last = (i == run_len - 1);
            pending_events.push_back(e);
        end
    endfunction

    function automatic bit code_is_ignored(input logic [7:0] code);
        case (code)
            SC_ALT_MAKE, SC_ALT_BRK, SC_UP, SC_DOWN:
                return 1'b1;
            SC_LEFT, SC_RIGHT, SC_LSHIFT_BRK, SC_RSHIFT_BRK, SC_CTRL_BRK:
                return 1'b0;
            default:
                return code >= SC_FIRST_BRK;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // called and returns at a falling edge; valid stays up for a following code
    task automatic send_code(input logic [7:0] code);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        key_code <= code;
        do
            @(posedge clk);
        while (!in_ready);
        predict_code(code);
        if (!code_is_ignored(code))
            counted_items++;
        @(negedge clk);
    endtask

    // codes that give no event may still be in flight, hence the settle time
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_limit  = cap;
    endtask

    task automatic hold_output(input int cycles);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    task automatic random_action();
        int         pick;
        int         n;
        logic [7:0] code;
        logic [7:0] shift_make;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            code = 8'($urandom_range(8'h39, 8'h01));
            send_code(code);
        end
        else if (pick < 50)
            send_code(KEY_BKSP);
        else if (pick < 57)
            send_code(KEY_TAB);
        else if (pick < 63)
            send_code(KEY_ENTER);
        else if (pick < 73)
            send_code($urandom_range(1) ? SC_LEFT : SC_RIGHT);
        else if (pick < 80)
        begin
            // shift held over a short burst of keys
            shift_make = $urandom_range(1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
            send_code(shift_make);
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                code = 8'($urandom_range(8'h35, 8'h02));
                send_code(code);
            end
            send_code(shift_make | BREAK_FLAG);
        end
        else if (pick < 84)
            send_code(SC_CAPS);
        else if (pick < 88)
        begin
            send_code(SC_CTRL_MAKE);
            send_code(KEY_L);
            send_code(SC_CTRL_BRK);
        end
        else if (pick < 93)
        begin
            code = BREAK_FLAG | 8'($urandom_range(8'h7F));
            send_code(code);
        end
        else
        begin
            code = 8'($urandom_range(8'hFF));
            send_code(code);
        end
    endtask

    task automatic test_case_mapping();
        send_code(SC_CAPS);
        send_code(KEY_A);
        send_code(SC_LSHIFT_MAKE);
        send_code(KEY_A);
        send_code(KEY_1);
        send_code(SC_LSHIFT_BRK);
        send_code(SC_RSHIFT_MAKE);
        send_code(KEY_SLASH);
        send_code(SC_RSHIFT_BRK);
        send_code(SC_CAPS);
    endtask

    task automatic test_cursor_and_erase();
        send_code(SC_RIGHT);
        send_code(SC_LEFT);
        send_code(SC_LEFT);
        send_code(KEY_BKSP);
        send_code(SC_CTRL_MAKE);
        send_code(KEY_L);
        send_code(SC_CTRL_BRK);
        send_code(KEY_TAB);
        send_code(KEY_ENTER);
        send_code(KEY_BKSP);
    endtask

    task automatic test_ignored_codes();
        send_code(SC_UP);
        send_code(KEY_NONE);
        send_code(KEY_TOP);
    endtask

    task automatic test_capacity_limits();
        wait_drain();
        write_capacity(7'd1);
        send_code(KEY_A);
        send_code(KEY_A);
        send_code(SC_CTRL_MAKE);
        send_code(KEY_L);
        send_code(SC_CTRL_BRK);
        send_code(KEY_BKSP);
        send_code(KEY_TAB);
        send_code(KEY_ENTER);
        wait_drain();
        // nothing printable gets in at zero capacity
        write_capacity(7'd0);
        send_code(KEY_TAB);
    endtask

    task automatic test_random_phase(input logic [6:0] cap, input int count);
        int target;
        wait_drain();
        write_capacity(cap);
        target = counted_items + count;
        while (counted_items < target)
            random_action();
    endtask

    // output held off while codes keep coming, then the sender waits for all events
    task automatic test_backpressure();
        fork
            hold_output(HOLD_CYCLES);
            repeat (16) random_action();
        join
        wait_drain();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_events
        line_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
                report_mismatch($sformatf("event kind %0d with nothing pending", event_kind));
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              event_kind, want.kind));
                if (character !== want.ch)
                    report_mismatch($sformatf("character 0x%0h, want 0x%0h",
                                              character, want.ch));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              last_of_run, want.last));
                if (fill_level !== want.fill)
                    report_mismatch($sformatf("fill_level %0d, want %0d",
                                              fill_level, want.fill));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 17;
        rx_idle_pct = 85;
        test_case_mapping();
        test_cursor_and_erase();
        test_ignored_codes();
        test_capacity_limits();
        test_random_phase(7'd127, 35);

        tx_idle_pct = 85;
        rx_idle_pct = 17;
        test_random_phase(7'($urandom_range(12, 2)), 35);
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_phase(7'($urandom_range(60, 13)), 30);
        wait_drain();

        if (error_count == 0 && pending_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
